// ===== hw/rtl/gcr3_pkg.sv =====
// Package for the 3-D Gaussian component rotation block.
// Holds the item types, configuration codes, round and clip helpers.
// No dependencies; every other file of the block imports it.
package gcr3_pkg;

    localparam int ROW_W     = 48;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW2 = 2'd2;

    localparam logic [ROW_W-1:0] ROW0_RST = 48'h0000_0000_4000;
    localparam logic [ROW_W-1:0] ROW1_RST = 48'h0000_4000_0000;
    localparam logic [ROW_W-1:0] ROW2_RST = 48'h4000_0000_0000;

    // Half an LSB of the Q16.16 result, in Q*.30 and Q*.44 respectively
    localparam logic signed [49:0] MEAN_RND = 50'sd8192;
    localparam logic signed [67:0] COV_RND  = 68'sd134217728;

    localparam logic signed [39:0] SAT_MAX = 40'sd2147483647;
    localparam logic signed [39:0] SAT_MIN = -40'sd2147483648;

    // Upper-triangle element order of the rotated covariance
    localparam logic [1:0] PAIR_J [6] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
    localparam logic [1:0] PAIR_K [6] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

    typedef logic [2:0][ROW_W-1:0] t_rows;
    typedef logic [2:0][2:0][49:0] t_tmat;

    typedef struct packed {
        logic signed [31:0] mean_x;
        logic signed [31:0] mean_y;
        logic signed [31:0] mean_z;
        logic signed [31:0] cov_xx;
        logic signed [31:0] cov_xy;
        logic signed [31:0] cov_xz;
        logic signed [31:0] cov_yy;
        logic signed [31:0] cov_yz;
        logic signed [31:0] cov_zz;
        logic               last_component;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] rot_mean_x;
        logic signed [31:0] rot_mean_y;
        logic signed [31:0] rot_mean_z;
        logic signed [31:0] rot_cov_xx;
        logic signed [31:0] rot_cov_xy;
        logic signed [31:0] rot_cov_xz;
        logic signed [31:0] rot_cov_yy;
        logic signed [31:0] rot_cov_yz;
        logic signed [31:0] rot_cov_zz;
        logic               saturated;
        logic               last_out;
    } t_out_item;

    // Register loads for the back half of the pipeline
    typedef struct packed {
        logic ld3;
        logic ld4;
    } t_bk_ctl;

    // Signed Q2.14 coefficient k of a packed rotation row
    function automatic logic signed [15:0] coef(input logic [ROW_W-1:0] row,
                                                input logic [1:0] k);
        return $signed(row[16*k +: 16]);
    endfunction

    // Clip to signed 32 bits; bit 32 flags a clip
    function automatic logic [32:0] sat32(input logic signed [39:0] v);
        if (v > SAT_MAX) begin
            return {1'b1, SAT_MAX[31:0]};
        end else if (v < SAT_MIN) begin
            return {1'b1, SAT_MIN[31:0]};
        end
        return {1'b0, v[31:0]};
    endfunction

endpackage

// ===== hw/rtl/gcr3_in_if.sv =====
// Input channel of the rotation block: valid/ready with one component.
// Depends on gcr3_pkg for the item type.
interface gcr3_in_if import gcr3_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/gcr3_out_if.sv =====
// Output channel of the rotation block: valid/ready with one result.
// Depends on gcr3_pkg for the item type.
interface gcr3_out_if import gcr3_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/gcr3_cov_back.sv =====
// Back half of the covariance path: R * T products, then sum, round and clip.
// Depends on gcr3_pkg; pipeline loads come from the top level.
module gcr3_cov_back import gcr3_pkg::*; (
    input  logic             i_clk,
    input  t_bk_ctl          i_ctl,
    input  t_rows            i_rows,
    input  t_tmat            i_t,
    output logic [5:0][31:0] o_cov,
    output logic             o_sat
);

    logic signed [67:0] n_pp [6][3];
    logic signed [67:0] r_pp [6][3];
    logic signed [67:0] n_sum [6];
    logic [32:0]        n_cs [6];
    logic [5:0]         n_flag;
    logic [5:0][31:0]   r_cov;
    logic               r_sat;

    always_comb begin
        for (int p = 0; p < 6; p++) begin
            for (int m = 0; m < 3; m++) begin
                n_pp[p][m] = 68'(coef(i_rows[PAIR_J[p]], 2'(m)))
                           * 68'($signed(i_t[m][PAIR_K[p]]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld3) begin
            r_pp <= n_pp;
        end
    end

    always_comb begin
        for (int p = 0; p < 6; p++) begin
            n_sum[p]  = r_pp[p][0] + r_pp[p][1] + r_pp[p][2] + COV_RND;
            n_cs[p]   = sat32($signed(n_sum[p][67:28]));
            n_flag[p] = n_cs[p][32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld4) begin
            for (int p = 0; p < 6; p++) begin
                r_cov[p] <= n_cs[p][31:0];
            end
            r_sat <= |n_flag;
        end
    end

    assign o_cov = r_cov;
    assign o_sat = r_sat;

endmodule

// ===== hw/rtl/gaussian_component_rotate_3d.sv =====
// Top level of the 3-D Gaussian component rotation block.
// Depends on gcr3_pkg, gcr3_in_if, gcr3_out_if and gcr3_cov_back.
//
// Usage:
//   i_item carries one mixture component per transfer (mean and the six
//   unique covariance entries, Q16.16). o_res returns R*mu and the upper
//   triangle of R*Sigma*R^T, rounded half up and clipped to 32 bits, with
//   a clip flag and the last flag copied through.
//   The rotation rows are written on i_cfg_we/i_cfg_idx/i_cfg_data, index 0
//   to 2; other indexes are dropped. Write them only while the block is idle.
// Timing:
//   Four register stages: products, three-term sums, second products (for the
//   mean, its rounding), and final sum with round and clip into the output
//   register. One item is taken every cycle while the output side keeps ready
//   high.
// Reset:
//   Synchronous, active low; empties the pipeline and loads the identity
//   rotation.
// Stall:
//   When o_res.ready is low, the stages fill up behind the output register
//   and i_item.ready drops once no stage has room; nothing is lost.
module gaussian_component_rotate_3d import gcr3_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ROW_W-1:0]     i_cfg_data,
    gcr3_in_if.sink              i_item,
    gcr3_out_if.source           o_res
);

    t_rows r_rows;

    logic r_v1, r_v2, r_v3, r_v4;
    logic r_last1, r_last2, r_last3, r_last4;
    logic en1, en2, en3, en4;

    logic signed [15:0] rc [3][3];
    logic signed [31:0] mu [3];
    logic signed [31:0] sg [3][3];

    logic signed [47:0] n_mp [3][3];
    logic signed [47:0] r_mp [3][3];
    logic signed [47:0] n_tp [3][3][3];
    logic signed [47:0] r_tp [3][3][3];

    logic signed [49:0] r_macc [3];
    t_tmat              r_t;

    logic signed [49:0] n_mrnd [3];
    logic signed [35:0] r_mr [3];
    logic [32:0]        n_ms [3];
    logic [31:0]        r_mean [3];
    logic               r_msat;

    logic [5:0][31:0]   cov;
    logic               cov_sat;
    t_bk_ctl            bk_ctl;
    logic               any_bound;

    // Configuration rows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows[0] <= ROW0_RST;
            r_rows[1] <= ROW1_RST;
            r_rows[2] <= ROW2_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROW0: r_rows[0] <= i_cfg_data;
                CFG_ROW1: r_rows[1] <= i_cfg_data;
                CFG_ROW2: r_rows[2] <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    // Pipeline advance: a stage takes new data when empty or when it drains
    assign en4 = !r_v4 || o_res.ready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign i_item.ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_item.valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
                rc[j][k] = coef(r_rows[j], 2'(k));
            end
        end
        mu[0]    = i_item.data.mean_x;
        mu[1]    = i_item.data.mean_y;
        mu[2]    = i_item.data.mean_z;
        sg[0][0] = i_item.data.cov_xx;
        sg[0][1] = i_item.data.cov_xy;
        sg[0][2] = i_item.data.cov_xz;
        sg[1][0] = i_item.data.cov_xy;
        sg[1][1] = i_item.data.cov_yy;
        sg[1][2] = i_item.data.cov_yz;
        sg[2][0] = i_item.data.cov_xz;
        sg[2][1] = i_item.data.cov_yz;
        sg[2][2] = i_item.data.cov_zz;
    end

    // Stage 1: R*mu and Sigma*R^T partial products
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
                n_mp[j][k] = 48'(rc[j][k]) * 48'(mu[k]);
            end
        end
        for (int m = 0; m < 3; m++) begin
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    n_tp[m][k][j] = 48'(sg[m][j]) * 48'(rc[k][j]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_item.valid) begin
            r_mp    <= n_mp;
            r_tp    <= n_tp;
            r_last1 <= i_item.data.last_component;
        end
    end

    // Stage 2: three-term sums
    always_ff @(posedge i_clk) begin
        if (en2 && r_v1) begin
            for (int j = 0; j < 3; j++) begin
                r_macc[j] <= 50'(r_mp[j][0]) + 50'(r_mp[j][1]) + 50'(r_mp[j][2]);
            end
            for (int m = 0; m < 3; m++) begin
                for (int k = 0; k < 3; k++) begin
                    r_t[m][k] <= 50'(r_tp[m][k][0]) + 50'(r_tp[m][k][1])
                               + 50'(r_tp[m][k][2]);
                end
            end
            r_last2 <= r_last1;
        end
    end

    // Stage 3: round the mean; covariance products in the back half
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_mrnd[j] = r_macc[j] + MEAN_RND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3 && r_v2) begin
            for (int j = 0; j < 3; j++) begin
                r_mr[j] <= n_mrnd[j][49:14];
            end
            r_last3 <= r_last2;
        end
    end

    // Stage 4: clip the mean into the output register
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_ms[j] = sat32(40'(r_mr[j]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4 && r_v3) begin
            for (int j = 0; j < 3; j++) begin
                r_mean[j] <= n_ms[j][31:0];
            end
            r_msat  <= n_ms[0][32] | n_ms[1][32] | n_ms[2][32];
            r_last4 <= r_last3;
        end
    end

    assign bk_ctl.ld3 = en3 && r_v2;
    assign bk_ctl.ld4 = en4 && r_v3;

    gcr3_cov_back u_cov_back (
        .i_clk  (i_clk),
        .i_ctl  (bk_ctl),
        .i_rows (r_rows),
        .i_t    (r_t),
        .o_cov  (cov),
        .o_sat  (cov_sat)
    );

    assign o_res.valid           = r_v4;
    assign o_res.data.rot_mean_x = r_mean[0];
    assign o_res.data.rot_mean_y = r_mean[1];
    assign o_res.data.rot_mean_z = r_mean[2];
    assign o_res.data.rot_cov_xx = cov[0];
    assign o_res.data.rot_cov_xy = cov[1];
    assign o_res.data.rot_cov_xz = cov[2];
    assign o_res.data.rot_cov_yy = cov[3];
    assign o_res.data.rot_cov_yz = cov[4];
    assign o_res.data.rot_cov_zz = cov[5];
    assign o_res.data.saturated  = r_msat | cov_sat;
    assign o_res.data.last_out   = r_last4;

    // A clip leaves at least one value sitting on a bound
    always_comb begin
        any_bound = 1'b0;
        for (int j = 0; j < 3; j++) begin
            any_bound |= (r_mean[j] == SAT_MAX[31:0]) || (r_mean[j] == SAT_MIN[31:0]);
        end
        for (int p = 0; p < 6; p++) begin
            any_bound |= (cov[p] == SAT_MAX[31:0]) || (cov[p] == SAT_MIN[31:0]);
        end
    end

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result offered straight after reset");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_v3 && r_v4 && !o_res.ready) |-> !i_item.ready)
        else $error("input taken while every stage is full and stalled");

    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.data.saturated) |-> any_bound)
        else $error("clip flag set with no value on a bound");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !r_v4) |=> r_v4)
        else $error("stage 3 result failed to move into an empty output register");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for gaussian_component_rotate_3d.
// Needs gcr3_pkg, gcr3_in_if, gcr3_out_if and the block's RTL; nothing else.
// Runs a directed table and then random components under many rotations.
`timescale 1ns / 1ps

module tb_top;
    import gcr3_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MINV = 32'sh8000_0000;

    localparam logic [15:0] Q_ONE     = 16'h4000;
    localparam logic [15:0] Q_NEG_ONE = 16'hC000;

    localparam t_rows ROT_ID   = {ROW2_RST, ROW1_RST, ROW0_RST};
    localparam t_rows ROT_NEG2 = {3{48'h8000_8000_8000}};
    localparam t_rows ROT_QMAX = {3{48'h7FFF_7FFF_7FFF}};
    localparam t_rows ROT_HALF = {48'h2000_0000_0000, 48'h0000_2000_0000,
                                  48'h0000_0000_2000};
    // quarter turn about z
    localparam t_rows ROT_ZQ   = {48'h4000_0000_0000, 48'h0000_0000_4000,
                                  48'h0000_C000_0000};

    localparam int UPPER_ROW [6] = '{0, 0, 0, 1, 1, 2};
    localparam int UPPER_COL [6] = '{0, 1, 2, 1, 2, 2};
    localparam int PERM_COL [6][3] = '{'{0, 1, 2}, '{0, 2, 1}, '{1, 0, 2},
                                       '{1, 2, 0}, '{2, 0, 1}, '{2, 1, 0}};

    localparam int LONG_HOLD    = 48;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 150;

    typedef enum {K_IDENT, K_QMAX, K_NEG2, K_RANDOM, K_PERM, K_SMALL} t_rot_kind;

    localparam t_rot_kind PHASE_KIND [RAND_PHASES] = '{K_SMALL, K_PERM, K_QMAX,
        K_RANDOM, K_NEG2, K_SMALL, K_IDENT, K_RANDOM};

    typedef struct {
        t_rows     rot;
        bit        spare_wr;
        bit        typed;
        t_in_item  c;
        t_out_item want;
    } t_stim_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [ROW_W-1:0]     i_cfg_data;

    gcr3_in_if  item_ch ();
    gcr3_out_if res_ch ();

    gaussian_component_rotate_3d dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_ch),
        .o_res      (res_ch)
    );

    t_rows       rot_now = ROT_ID;
    t_out_item   rotated_q [$];
    t_stim_row   stim_tab [$];
    bit          next_typed;
    t_out_item   next_want;
    bit          sink_idle_on = 1'b1;
    int          hold_req = 0;
    int          err_cnt = 0;
    int          checked_cnt = 0;
    int          clipped_cnt = 0;
    int          last_cnt = 0;
    int          settings_cnt = 0;

    string value_name [9] = '{"rot_mean_x", "rot_mean_y", "rot_mean_z",
                              "rot_cov_xx", "rot_cov_xy", "rot_cov_xz",
                              "rot_cov_yy", "rot_cov_yz", "rot_cov_zz"};

    always #1 i_clk = ~i_clk;

    initial begin
        #400000;
        $display("FAIL");
        $finish;
    end

    // Clip to signed 32 bits; bit 32 marks a clip
    function automatic logic [32:0] clip32(input logic signed [127:0] v);
        if (v > 128'sd2147483647) begin
            return {1'b1, MAXV};
        end else if (v < -128'sd2147483648) begin
            return {1'b1, MINV};
        end
        return {1'b0, v[31:0]};
    endfunction

    function automatic t_out_item rotate_component(input t_in_item c);
        logic signed [15:0]  r [3][3];
        logic signed [31:0]  mu [3];
        logic signed [31:0]  sg [3][3];
        logic signed [127:0] t [3][3];
        logic signed [127:0] acc;
        logic signed [31:0]  q [9];
        logic [32:0]         cv;
        logic                clip;
        t_out_item           o;
        clip = 1'b0;
        for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
                r[j][k] = rot_now[j][16*k +: 16];
            end
        end
        mu[0] = c.mean_x;
        mu[1] = c.mean_y;
        mu[2] = c.mean_z;
        sg[0][0] = c.cov_xx;
        sg[0][1] = c.cov_xy;
        sg[1][0] = c.cov_xy;
        sg[0][2] = c.cov_xz;
        sg[2][0] = c.cov_xz;
        sg[1][1] = c.cov_yy;
        sg[1][2] = c.cov_yz;
        sg[2][1] = c.cov_yz;
        sg[2][2] = c.cov_zz;
        for (int j = 0; j < 3; j++) begin
            acc = 0;
            for (int k = 0; k < 3; k++) begin
                acc = acc + r[j][k] * mu[k];
            end
            cv = clip32((acc + 8192) >>> 14);
            q[j] = cv[31:0];
            clip |= cv[32];
        end
        // Sigma * R^T first, then R on the left, all exact
        for (int m = 0; m < 3; m++) begin
            for (int k = 0; k < 3; k++) begin
                t[m][k] = 0;
                for (int j = 0; j < 3; j++) begin
                    t[m][k] = t[m][k] + sg[m][j] * r[k][j];
                end
            end
        end
        for (int p = 0; p < 6; p++) begin
            acc = 0;
            for (int m = 0; m < 3; m++) begin
                acc = acc + r[UPPER_ROW[p]][m] * t[m][UPPER_COL[p]];
            end
            cv = clip32((acc + 134217728) >>> 28);
            q[3+p] = cv[31:0];
            clip |= cv[32];
        end
        o.rot_mean_x = q[0];
        o.rot_mean_y = q[1];
        o.rot_mean_z = q[2];
        o.rot_cov_xx = q[3];
        o.rot_cov_xy = q[4];
        o.rot_cov_xz = q[5];
        o.rot_cov_yy = q[6];
        o.rot_cov_yz = q[7];
        o.rot_cov_zz = q[8];
        o.saturated  = clip;
        o.last_out   = c.last_component;
        return o;
    endfunction

    function automatic t_in_item comp(input logic signed [31:0] mx, my, mz,
                                      input logic signed [31:0] xx, xy, xz, yy, yz, zz,
                                      input logic last);
        t_in_item c;
        c = '{mx, my, mz, xx, xy, xz, yy, yz, zz, last};
        return c;
    endfunction

    function automatic t_in_item uniform(input logic signed [31:0] v, input logic last);
        return comp(v, v, v, v, v, v, v, v, v, last);
    endfunction

    function automatic t_out_item res9(input logic signed [31:0] mx, my, mz,
                                       input logic signed [31:0] xx, xy, xz, yy, yz, zz,
                                       input logic sat, input logic last);
        t_out_item o;
        o = '{mx, my, mz, xx, xy, xz, yy, yz, zz, sat, last};
        return o;
    endfunction

    // Identity rotation hands every value through untouched
    function automatic t_out_item copied(input t_in_item c);
        return res9(c.mean_x, c.mean_y, c.mean_z, c.cov_xx, c.cov_xy, c.cov_xz,
                    c.cov_yy, c.cov_yz, c.cov_zz, 1'b0, c.last_component);
    endfunction

    function automatic void add_row(input t_rows rot, input bit spare, input bit typed,
                                    input t_in_item c, input t_out_item want);
        t_stim_row s;
        s.rot = rot;
        s.spare_wr = spare;
        s.typed = typed;
        s.c = c;
        s.want = want;
        stim_tab.push_back(s);
    endfunction

    function automatic logic signed [31:0] draw_q16();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom;
            5, 6, 7:       return {{12{1'b0}}, 20'($urandom)} - 32'sd524288;
            default: begin
                case ($urandom_range(0, 4))
                    0: return MAXV;
                    1: return MINV;
                    2: return 0;
                    3: return -1;
                    default: return 1;
                endcase
            end
        endcase
    endfunction

    function automatic t_in_item draw_component();
        return comp(draw_q16(), draw_q16(), draw_q16(), draw_q16(), draw_q16(),
                    draw_q16(), draw_q16(), draw_q16(), draw_q16(),
                    $urandom_range(0, 7) == 0);
    endfunction

    function automatic t_rows draw_rows(input t_rot_kind kind);
        t_rows r;
        int    p;
        r = '0;
        case (kind)
            K_IDENT: r = ROT_ID;
            K_QMAX:  r = ROT_QMAX;
            K_NEG2:  r = ROT_NEG2;
            K_RANDOM: begin
                for (int j = 0; j < 3; j++) begin
                    r[j] = {16'($urandom), 32'($urandom)};
                end
            end
            K_PERM: begin
                p = $urandom_range(0, 5);
                for (int j = 0; j < 3; j++) begin
                    r[j][16*PERM_COL[p][j] +: 16] = $urandom_range(0, 1) ? Q_ONE : Q_NEG_ONE;
                end
            end
            default: begin
                for (int j = 0; j < 3; j++) begin
                    for (int k = 0; k < 3; k++) begin
                        r[j][16*k +: 16] = 16'($urandom_range(0, 32768) - 16384);
                    end
                end
            end
        endcase
        return r;
    endfunction

    // Called at a falling edge; leaves the write enable high
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [ROW_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_ROW0: rot_now[0] = val;
            CFG_ROW1: rot_now[1] = val;
            CFG_ROW2: rot_now[2] = val;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic load_config(input t_rows r, input bit spare);
        cfg_write(CFG_ROW0, r[0]);
        cfg_write(CFG_ROW1, r[1]);
        cfg_write(CFG_ROW2, r[2]);
        if (spare) begin
            cfg_write(CFG_SPARE, {16'($urandom), 32'($urandom)});
        end
        i_cfg_we <= 1'b0;
        settings_cnt++;
    endtask

    // Drop valid and wait for the pipeline to empty
    task automatic settle();
        item_ch.valid <= 1'b0;
        while (rotated_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic offer_component(input t_in_item c, input int gap, input bit typed,
                                   input t_out_item want);
        next_typed = typed;
        next_want  = want;
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= c;
        do begin
            @(posedge i_clk);
        end while (!item_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic check_result(input t_out_item got, input t_out_item want);
        logic signed [31:0] g [9];
        logic signed [31:0] w [9];
        g = '{got.rot_mean_x, got.rot_mean_y, got.rot_mean_z, got.rot_cov_xx,
              got.rot_cov_xy, got.rot_cov_xz, got.rot_cov_yy, got.rot_cov_yz,
              got.rot_cov_zz};
        w = '{want.rot_mean_x, want.rot_mean_y, want.rot_mean_z, want.rot_cov_xx,
              want.rot_cov_xy, want.rot_cov_xz, want.rot_cov_yy, want.rot_cov_yz,
              want.rot_cov_zz};
        for (int i = 0; i < 9; i++) begin
            if (g[i] !== w[i]) begin
                $error("%s: expected %0d, got %0d", value_name[i], w[i], g[i]);
                err_cnt++;
            end
        end
        if (got.saturated !== want.saturated) begin
            $error("saturated: expected %0b, got %0b", want.saturated, got.saturated);
            err_cnt++;
        end
        if (got.last_out !== want.last_out) begin
            $error("last_out: expected %0b, got %0b", want.last_out, got.last_out);
            err_cnt++;
        end
        checked_cnt++;
        clipped_cnt += want.saturated;
        last_cnt += want.last_out;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && item_ch.valid && item_ch.ready) begin
            if (next_typed) begin
                rotated_q.push_back(next_want);
            end else begin
                rotated_q.push_back(rotate_component(item_ch.data));
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (rotated_q.size() == 0) begin
                $error("result transfer with nothing expected");
                err_cnt++;
            end else begin
                check_result(res_ch.data, rotated_q.pop_front());
            end
        end
    end

    // Receiver: random stalls, plus one long hold when asked
    initial begin
        res_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_req != 0) begin
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_req = 0;
            end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
                @(negedge i_clk);
            end
        end
    end

    initial begin
        int gap;
        bit src_idle_on;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_ROW0;
        i_cfg_data    = '0;
        item_ch.valid = 1'b0;
        item_ch.data  = '0;

        add_row(ROT_ID, 0, 1, uniform(0, 0), copied(uniform(0, 0)));
        add_row(ROT_ID, 0, 1, uniform(MAXV, 1), copied(uniform(MAXV, 1)));
        add_row(ROT_ID, 0, 1, uniform(MINV, 0), copied(uniform(MINV, 0)));
        add_row(ROT_ID, 0, 1,
                comp(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                     32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                     32'h5555_5555, 1),
                copied(comp(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                            32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                            32'h5555_5555, 1)));
        add_row(ROT_ID, 0, 1, uniform(-1, 0), copied(uniform(-1, 0)));
        add_row(ROT_ID, 0, 1, uniform(1, 1), copied(uniform(1, 1)));
        // Scale far beyond range: every value clips
        add_row(ROT_NEG2, 0, 1, uniform(MINV, 1),
                res9(MAXV, MAXV, MAXV, MINV, MINV, MINV, MINV, MINV, MINV, 1, 1));
        add_row(ROT_NEG2, 0, 1, uniform(MAXV, 0),
                res9(MINV, MINV, MINV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, 1, 0));
        add_row(ROT_NEG2, 0, 0, comp(32'h0001_8000, -32'sh0002_4000, 32'h0000_0001,
                                     32'h0003_0000, -32'sh0000_8000, 32'h0000_4000,
                                     32'h0002_0000, 32'h0000_0003, 32'h0001_0000, 0), '0);
        add_row(ROT_QMAX, 0, 0, uniform(MAXV, 0), '0);
        add_row(ROT_QMAX, 0, 0, comp(-32'sh0000_1234, 32'h0000_5678, MINV, 32'h0000_0001,
                                     -32'sh0000_0001, 32'h0123_4567, -32'sh0765_4321,
                                     MAXV, 32'h0000_FFFF, 1), '0);
        // Halving exposes the ties: they must round upward
        add_row(ROT_HALF, 0, 1, comp(1, -1, 3, 2, -2, 1, -1, 3, -3, 0),
                res9(1, 0, 2, 1, 0, 0, 0, 1, -1, 0, 0));
        add_row(ROT_HALF, 0, 0, comp(-3, 5, -5, 6, -6, 7, -7, 9, -9, 1), '0);
        add_row(ROT_ZQ, 0, 0, comp(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                                   32'h0004_0000, 32'h0000_8000, -32'sh0001_0000,
                                   32'h0005_0000, 32'h0000_4000, 32'h0006_0000, 0), '0);
        // Write to an unused index must leave the rotation alone
        add_row(ROT_ZQ, 1, 0, comp(MAXV, MINV, -1, MINV, MAXV, 1, -1, MINV, MAXV, 1), '0);
        add_row(ROT_ZQ, 0, 0, comp(-32'sh0000_0007, 32'h7FFF_0000, 32'h8000_0001,
                                   32'h0000_0010, 32'h0000_0020, 32'h0000_0030,
                                   32'h0000_0040, 32'h0000_0050, 32'h0000_0060, 0), '0);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (stim_tab[i]) begin
            if (stim_tab[i].rot != rot_now || stim_tab[i].spare_wr) begin
                settle();
                load_config(stim_tab[i].rot, stim_tab[i].spare_wr);
            end
            offer_component(stim_tab[i].c, 0, stim_tab[i].typed, stim_tab[i].want);
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            settle();
            load_config(draw_rows(PHASE_KIND[ph]), 1'b0);
            // last stretch runs flat out on both sides
            src_idle_on  = (ph < RAND_PHASES - 1);
            sink_idle_on = src_idle_on;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 1 && n == 40) begin
                    hold_req = 1;
                end
                if (ph == 3 && n == 75) begin
                    settle();
                end
                gap = 0;
                if (src_idle_on && !(ph == 1 && n >= 40 && n < 70)
                        && $urandom_range(0, 4) == 0) begin
                    gap = $urandom_range(1, 6);
                end
                offer_component(draw_component(), gap, 1'b0, '0);
            end
        end

        settle();
        repeat (8) @(posedge i_clk);
        $display("Checked %0d rotated components over %0d rotation settings.",
                 checked_cnt, settings_cnt);
        $display("%0d of them clipped, %0d carried the last marker, %0d mismatches.",
                 clipped_cnt, last_cnt, err_cnt);
        if (err_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/gcr3_pkg.sv
hw/rtl/gcr3_in_if.sv
hw/rtl/gcr3_out_if.sv
hw/rtl/gcr3_cov_back.sv
hw/rtl/gaussian_component_rotate_3d.sv
verif/tb_top.sv
